// ===== hdl/scmd_pkg.sv =====
// Package for the serial command interpreter: parse states, reply codes,
// ASCII character constants and the result record passed out of the parser.
// No dependencies.
package scmd_pkg;

    typedef enum logic [3:0] {
        PS_IDLE,
        PS_LED,
        PS_LED_SET,
        PS_LED_CLEAR,
        PS_LED_READ,
        PS_SWITCH,
        PS_BUZ_HUNDREDS,
        PS_BUZ_TENS,
        PS_BUZ_UNITS,
        PS_COOL_TENS,
        PS_COOL_UNITS,
        PS_HEAT_TENS,
        PS_HEAT_UNITS
    } parse_state_t;

    typedef enum logic [1:0] {
        REPLY_ACK    = 2'd0,
        REPLY_ERR    = 2'd1,
        REPLY_CLOSED = 2'd2,
        REPLY_OPEN   = 2'd3
    } reply_t;

    localparam logic [7:0] CHAR_L    = 8'h4C;
    localparam logic [7:0] CHAR_S    = 8'h53;
    localparam logic [7:0] CHAR_B    = 8'h42;
    localparam logic [7:0] CHAR_C    = 8'h43;
    localparam logic [7:0] CHAR_H    = 8'h48;
    localparam logic [7:0] CHAR_R    = 8'h52;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_ONE  = 8'h31;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    localparam int BUZ_W   = 10;
    localparam int LEVEL_W = 7;
    localparam int SW_W    = 4;
    localparam int LED_W   = 4;

    typedef struct packed {
        reply_t               reply;
        logic                 buzzer_update;
        logic [BUZ_W-1:0]     buzzer_ms;
        logic                 cooler_update;
        logic [LEVEL_W-1:0]   cooler_speed;
        logic                 heater_update;
        logic [LEVEL_W-1:0]   heater_power;
        logic [LED_W-1:0]     led_flags_out;
    } result_t;

endpackage

// ===== hdl/serial_command_interpreter_core.sv =====
// Top level of the serial command interpreter: stream ports, parse state,
// accumulators, LED flags and the result register.
// Depends on scmd_pkg and scmd_parse.

// Takes one received ASCII byte per cycle on the s_ stream, with the switch
// levels alongside, and answers each completed or rejected command with one
// result item on the m_ stream; bytes in the middle of a command give none.
// Every byte is decoded in the cycle it is accepted, against the parse state
// and accumulators held in registers, so a byte can be taken every cycle. The
// only stall comes from the single result register: while it holds an item
// that m_tready has not taken, no new byte is accepted.
module serial_command_interpreter_core #(
    parameter int NUM_CHANNELS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // rx_byte[7:0], switch_levels[11:8], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    // reply[1:0], buzzer_update[2], buzzer_ms[12:3], cooler_update[13],
    // cooler_speed[20:14], heater_update[21], heater_power[28:22],
    // led_flags_out[32:29], zero pad
    output logic [39:0] m_tdata
);
    import scmd_pkg::*;

    localparam int RES_W = $bits(result_t);

    parse_state_t              state_reg, state_next;
    logic [NUM_CHANNELS-1:0]   led_reg, led_next;
    logic [BUZ_W-1:0]          buz_reg, buz_next;
    logic [LEVEL_W-1:0]        cool_reg, cool_next;
    logic [LEVEL_W-1:0]        heat_reg, heat_next;
    logic                      out_valid_reg;
    result_t                   result_reg, result_next;
    logic                      emit;
    logic                      accept;

    scmd_parse #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_parse (
        .state             (state_reg),
        .rx_byte           (s_tdata[7:0]),
        .switch_levels     (s_tdata[11:8]),
        .led_flags         (led_reg),
        .buzzer_accum      (buz_reg),
        .cooler_accum      (cool_reg),
        .heater_accum      (heat_reg),
        .state_next        (state_next),
        .led_flags_next    (led_next),
        .buzzer_accum_next (buz_next),
        .cooler_accum_next (cool_next),
        .heater_accum_next (heat_next),
        .emit              (emit),
        .result            (result_next)
    );

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= PS_IDLE;
            led_reg       <= '0;
            buz_reg       <= '0;
            cool_reg      <= '0;
            heat_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                state_reg <= state_next;
                led_reg   <= led_next;
                buz_reg   <= buz_next;
                cool_reg  <= cool_next;
                heat_reg  <= heat_next;
            end
            if (accept) begin
                out_valid_reg <= emit;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload: load on every accept, hold otherwise
    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;

    always_comb begin
        m_tdata             = '0;
        m_tdata[1:0]        = result_reg.reply;
        m_tdata[2]          = result_reg.buzzer_update;
        m_tdata[12:3]       = result_reg.buzzer_ms;
        m_tdata[13]         = result_reg.cooler_update;
        m_tdata[20:14]      = result_reg.cooler_speed;
        m_tdata[21]         = result_reg.heater_update;
        m_tdata[28:22]      = result_reg.heater_power;
        m_tdata[32:29]      = result_reg.led_flags_out;
        m_tdata[39:RES_W]   = '0;
    end

endmodule

// ===== hdl/scmd_parse.sv =====
// Combinational command parser: next parse state, accumulators, LED flags
// and the result record for one received byte.
// Depends on scmd_pkg.
module scmd_parse #(
    parameter int NUM_CHANNELS = 4
) (
    input  scmd_pkg::parse_state_t                    state,
    input  logic [7:0]                                rx_byte,
    input  logic [scmd_pkg::SW_W-1:0]                 switch_levels,
    input  logic [NUM_CHANNELS-1:0]                   led_flags,
    input  logic [scmd_pkg::BUZ_W-1:0]                buzzer_accum,
    input  logic [scmd_pkg::LEVEL_W-1:0]              cooler_accum,
    input  logic [scmd_pkg::LEVEL_W-1:0]              heater_accum,
    output scmd_pkg::parse_state_t                    state_next,
    output logic [NUM_CHANNELS-1:0]                   led_flags_next,
    output logic [scmd_pkg::BUZ_W-1:0]                buzzer_accum_next,
    output logic [scmd_pkg::LEVEL_W-1:0]              cooler_accum_next,
    output logic [scmd_pkg::LEVEL_W-1:0]              heater_accum_next,
    output logic                                      emit,
    output scmd_pkg::result_t                         result
);
    import scmd_pkg::*;

    logic [NUM_CHANNELS-1:0]      chan_sel;
    logic [NUM_CHANNELS+SW_W-1:0] chan_sel_wide;
    logic [NUM_CHANNELS+LED_W-1:0] led_wide;
    logic                         is_chan;
    logic                         is_dec;
    logic [3:0]                   digit;
    logic                         err;
    logic [BUZ_W-1:0]             buz_sum;
    logic [LEVEL_W-1:0]           cool_sum;
    logic [LEVEL_W-1:0]           heat_sum;

    // one-hot channel select from the digit '1'..'0'+NUM_CHANNELS
    always_comb begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            chan_sel[i] = (rx_byte == 8'(CHAR_ONE + i));
        end
    end

    assign is_chan       = |chan_sel;
    assign is_dec        = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
    assign digit         = 4'(rx_byte - CHAR_ZERO);
    assign chan_sel_wide = {{SW_W{1'b0}}, chan_sel};
    assign buz_sum       = BUZ_W'(buzzer_accum + BUZ_W'(digit));
    assign cool_sum      = LEVEL_W'(cooler_accum + LEVEL_W'(digit));
    assign heat_sum      = LEVEL_W'(heater_accum + LEVEL_W'(digit));

    always_comb begin
        state_next        = PS_IDLE;
        led_flags_next    = led_flags;
        buzzer_accum_next = buzzer_accum;
        cooler_accum_next = cooler_accum;
        heater_accum_next = heater_accum;
        emit              = 1'b0;
        err               = 1'b0;
        result            = '0;
        result.reply      = REPLY_ACK;

        unique case (state)
            PS_IDLE: begin
                if (rx_byte == CHAR_L)      state_next = PS_LED;
                else if (rx_byte == CHAR_S) state_next = PS_SWITCH;
                else if (rx_byte == CHAR_B) state_next = PS_BUZ_HUNDREDS;
                else if (rx_byte == CHAR_C) state_next = PS_COOL_TENS;
                else if (rx_byte == CHAR_H) state_next = PS_HEAT_TENS;
                else                        err = 1'b1;
            end
            PS_LED: begin
                if (rx_byte == CHAR_S)      state_next = PS_LED_SET;
                else if (rx_byte == CHAR_C) state_next = PS_LED_CLEAR;
                else if (rx_byte == CHAR_R) state_next = PS_LED_READ;
                else                        err = 1'b1;
            end
            PS_LED_SET: begin
                if (is_chan) begin
                    led_flags_next = led_flags | chan_sel;
                    emit           = 1'b1;
                end else begin
                    err = 1'b1;
                end
            end
            PS_LED_CLEAR: begin
                if (is_chan) begin
                    led_flags_next = led_flags & ~chan_sel;
                    emit           = 1'b1;
                end else begin
                    err = 1'b1;
                end
            end
            PS_LED_READ: begin
                if (is_chan) begin
                    emit         = 1'b1;
                    result.reply = (|(led_flags & chan_sel)) ? REPLY_CLOSED : REPLY_OPEN;
                end else begin
                    err = 1'b1;
                end
            end
            PS_SWITCH: begin
                // channels above the switch count always read open
                if (is_chan) begin
                    emit         = 1'b1;
                    result.reply = (|(switch_levels & chan_sel_wide[SW_W-1:0])) ?
                                   REPLY_CLOSED : REPLY_OPEN;
                end else begin
                    err = 1'b1;
                end
            end
            PS_BUZ_HUNDREDS: begin
                if (is_dec) begin
                    buzzer_accum_next = BUZ_W'(BUZ_W'(digit) * BUZ_W'(100));
                    state_next        = PS_BUZ_TENS;
                end else begin
                    err = 1'b1;
                end
            end
            PS_BUZ_TENS: begin
                if (is_dec) begin
                    buzzer_accum_next = BUZ_W'(buzzer_accum + BUZ_W'(digit) * BUZ_W'(10));
                    state_next        = PS_BUZ_UNITS;
                end else begin
                    err = 1'b1;
                end
            end
            PS_BUZ_UNITS: begin
                if (is_dec) begin
                    buzzer_accum_next    = buz_sum;
                    emit                 = 1'b1;
                    result.buzzer_update = 1'b1;
                    result.buzzer_ms     = buz_sum;
                end else begin
                    err = 1'b1;
                end
            end
            PS_COOL_TENS: begin
                if (is_dec) begin
                    cooler_accum_next = LEVEL_W'(LEVEL_W'(digit) * LEVEL_W'(10));
                    state_next        = PS_COOL_UNITS;
                end else begin
                    err = 1'b1;
                end
            end
            PS_COOL_UNITS: begin
                if (is_dec) begin
                    cooler_accum_next    = cool_sum;
                    emit                 = 1'b1;
                    result.cooler_update = 1'b1;
                    result.cooler_speed  = cool_sum;
                end else begin
                    err = 1'b1;
                end
            end
            PS_HEAT_TENS: begin
                if (is_dec) begin
                    heater_accum_next = LEVEL_W'(LEVEL_W'(digit) * LEVEL_W'(10));
                    state_next        = PS_HEAT_UNITS;
                end else begin
                    err = 1'b1;
                end
            end
            PS_HEAT_UNITS: begin
                if (is_dec) begin
                    heater_accum_next    = heat_sum;
                    emit                 = 1'b1;
                    result.heater_update = 1'b1;
                    result.heater_power  = heat_sum;
                end else begin
                    err = 1'b1;
                end
            end
            default: begin
                err = 1'b1;
            end
        endcase

        if (err) begin
            emit         = 1'b1;
            result.reply = REPLY_ERR;
        end

        // LEDs above the fourth are kept but not reported
        led_wide             = {{LED_W{1'b0}}, led_flags_next};
        result.led_flags_out = led_wide[LED_W-1:0];
    end

endmodule
